[rtl/dect_pkg.sv]
// Shared constants, register codes and interface structs for the echo tone chain.
`default_nettype none

package dect_pkg;

    // parameter defaults
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int STATE_BITS_DEF  = 24;

    // Q0.16 coefficients
    localparam int COEF_BITS = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int HOLD_W     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TONE     = 3'd0,
        REG_HP       = 3'd1,
        REG_LP       = 3'd2,
        REG_HARSH    = 3'd3,
        REG_AMOUNT   = 3'd4,
        REG_HOLD     = 3'd5,
        REG_BITS     = 3'd6,
        REG_SLOPE    = 3'd7
    } cfg_idx_t;

    // register reset values
    localparam logic [COEF_BITS-1:0] TONE_RST   = 16'd45000;
    localparam logic [COEF_BITS-1:0] HP_RST     = 16'd1030;
    localparam logic [COEF_BITS-1:0] LP_RST     = 16'd35000;
    localparam logic [COEF_BITS-1:0] HARSH_RST  = 16'd26000;
    localparam logic [COEF_BITS-1:0] AMOUNT_RST = 16'd12000;
    localparam logic [HOLD_W-1:0]    HOLD_RST   = 4'd0;
    localparam logic [HOLD_W-1:0]    BITS_RST   = 4'd14;
    localparam logic [COEF_BITS-1:0] SLOPE_RST  = 16'd7864;

    // lo-fi stage
    localparam logic [COEF_BITS-1:0] LOFI_BLEND = 16'd51118;  // 0.78 in Q0.16
    localparam logic [HOLD_W-1:0]    HOLD_MIN   = 4'd2;
    localparam logic [HOLD_W-1:0]    HOLD_MAX   = 4'd12;
    localparam logic [HOLD_W-1:0]    BITS_MIN   = 4'd10;
    localparam logic [HOLD_W-1:0]    BITS_MAX   = 4'd14;

    // body compression divider: denominator is 2^32 + scaled |y|*k
    localparam int DIV_STEPS = 32;
    localparam int DEN_W     = 35;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic                 sub;    // base minus rounded product
        logic [COEF_BITS-1:0] coeff;
    } alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/dect_alu.sv]
// Shared two-stage multiply, round, add and saturate unit.
`default_nettype none

module dect_alu
    import dect_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEF
) (
    input  logic                          aclk,
    input  alu_ctl_t                      ctl,
    input  logic signed [STATE_BITS-1:0]  base,
    input  logic signed [STATE_BITS+1:0]  diff,
    output logic signed [STATE_BITS-1:0]  res,
    output logic signed [STATE_BITS+18:0] prod
);

    localparam int DW = STATE_BITS + 2;
    localparam int PW = DW + COEF_BITS + 1;
    localparam int XW = STATE_BITS + 4;
    localparam logic signed [PW-1:0] HALF = PW'(1 << (COEF_BITS - 1));
    localparam logic signed [XW-1:0] SAT_HI = $signed({{5{1'b0}}, {(STATE_BITS-1){1'b1}}});
    localparam logic signed [XW-1:0] SAT_LO = $signed({{5{1'b1}}, {(STATE_BITS-1){1'b0}}});

    logic signed [PW-1:0]         prod_reg;
    logic signed [STATE_BITS-1:0] base_reg;
    logic                         sub_reg;

    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] shf;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] sum;

    function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [XW-1:0] v);
        if (v > SAT_HI) begin
            return STATE_BITS'(SAT_HI);
        end else if (v < SAT_LO) begin
            return STATE_BITS'(SAT_LO);
        end
        return STATE_BITS'(v);
    endfunction

    always_ff @(posedge aclk) begin
        prod_reg <= diff * $signed({1'b0, ctl.coeff});
        base_reg <= base;
        sub_reg  <= ctl.sub;
    end

    always_comb begin
        rnd = prod_reg + HALF;
        shf = rnd >>> COEF_BITS;
        r_x = XW'(shf);
        if (sub_reg) begin
            sum = XW'(base_reg) - r_x;
        end else begin
            sum = XW'(base_reg) + r_x;
        end
        res = sat_st(sum);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/dect_div.sv]
// Restoring divider, one quotient bit per cycle, for body compression.
`default_nettype none

module dect_div
    import dect_pkg::*;
#(
    parameter int STATE_BITS = STATE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [STATE_BITS-1:0] mag,
    input  logic [DEN_W-1:0]      den,
    output div_stat_t             stat,
    output logic [STATE_BITS-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_STEPS-1:0] q_reg;

    logic [DEN_W-1:0] rem_dbl;
    logic             fits;

    // mag < 2^32 <= den, so the integer part is zero and only zeros shift in
    always_comb begin
        rem_dbl = rem_reg << 1;
        fits    = (rem_dbl >= den_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(mag);
            den_reg <= den;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? (rem_dbl - den_reg) : rem_dbl;
            q_reg   <= {q_reg[DIV_STEPS-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg[STATE_BITS-1:0];

endmodule

`default_nettype wire

[rtl/delay_echo_tone_chain.sv]
// Top level: per-channel echo conditioning chain under a small sequencer.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: sample_in; s_tuser: channel
//  m_      | out | m_tvalid/m_tready  | m_tdata: sample_out
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index: register, cfg_data: value
//
// From accept to the next free slot, one item makes six passes through the shared multiply
// unit with lo-fi off and seven with lo-fi on, plus a quantize step when lo-fi is on, one
// pass for |y|*k and the 32-step divider; no new item is taken in between.
// Reset (aresetn low, synchronous) clears all filter state, countdowns and the
// registers to their defaults. A result waiting on m_tready holds the block in
// its output step; the next item is taken once the result is in m_tdata.
`default_nettype none

module delay_echo_tone_chain
    import dect_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int STATE_BITS  = STATE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  logic                                 s_tuser,   // [0] channel
    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CFG_IDX_W-1:0]                 cfg_index,
    input  logic [CFG_DATA_W-1:0]                cfg_data
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FRAC    = STATE_BITS - 2;
    localparam int DW      = STATE_BITS + 2;
    localparam int PW      = DW + COEF_BITS + 1;
    localparam int XW      = STATE_BITS + 4;
    localparam int IN_K    = FRAC - (SAMPLE_BITS - 1);
    localparam int OUT_K   = (SAMPLE_BITS - 1) - FRAC;
    localparam int DEN_RSH = (FRAC >= COEF_BITS) ? FRAC - COEF_BITS : 0;
    localparam int DEN_LSH = (FRAC >= COEF_BITS) ? 0 : COEF_BITS - FRAC;
    localparam logic signed [XW-1:0] SAT_HI = $signed({{5{1'b0}}, {(STATE_BITS-1){1'b1}}});
    localparam logic signed [XW-1:0] SAT_LO = $signed({{5{1'b1}}, {(STATE_BITS-1){1'b0}}});
    localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1) << DIV_STEPS;

    typedef logic signed [STATE_BITS-1:0] st_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TONE,
        ST_HP,
        ST_LP,
        ST_HL,
        ST_HHL,
        ST_AMT,
        ST_QUANT,
        ST_LOFI,
        ST_BODY,
        ST_DIV,
        ST_OUT
    } state_t;

    // ---------------- registers ----------------
    logic [COEF_BITS-1:0] tone_reg, hp_reg, lp_reg, harsh_reg, amount_reg, slope_reg;
    logic [HOLD_W-1:0]    hold_reg, bits_reg;

    // per-channel filter state
    st_word_t          ch_tlp_reg  [2];
    st_word_t          ch_hpt_reg  [2];
    st_word_t          ch_lpo_reg  [2];
    st_word_t          ch_hlo_reg  [2];
    st_word_t          ch_hhl_reg  [2];
    st_word_t          ch_held_reg [2];
    logic [HOLD_W-1:0] ch_cnt_reg  [2];

    // working copy of the active channel
    state_t            st_reg;
    logic              ph_reg;      // 0: operands to the multiplier, 1: result back
    logic              chan_reg;
    st_word_t          x_reg, y_reg, a_reg;
    st_word_t          tlp_reg, hpt_reg, lpo_reg, hlo_reg, hhl_reg, held_reg;
    logic [HOLD_W-1:0] cnt_reg;
    logic              neg_reg;
    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] o_data_reg;

    // ---------------- shared unit hookup ----------------
    alu_ctl_t          alu_ctl;
    st_word_t          alu_base;
    logic signed [DW-1:0] alu_diff;
    st_word_t          alu_res;
    logic signed [PW-1:0] alu_prod;

    div_stat_t              div_stat;
    logic                   div_start;
    logic [STATE_BITS-1:0]  div_quot;
    logic [DEN_W-1:0]       div_den;

    st_word_t                x_ld;
    logic [STATE_BITS:0]     y_mag;
    logic [HOLD_W-1:0]       hold_c, bits_c;
    logic [5:0]              q_k;
    logic [STATE_BITS:0]     q_half, q_mask, q_rnd;
    logic signed [XW-1:0]    q_sv;
    st_word_t                q_val;
    logic signed [STATE_BITS:0] o_y;
    logic [SAMPLE_BITS-1:0]  o_samp;

    function automatic st_word_t sat_st(input logic signed [XW-1:0] v);
        if (v > SAT_HI) begin
            return STATE_BITS'(SAT_HI);
        end else if (v < SAT_LO) begin
            return STATE_BITS'(SAT_LO);
        end
        return STATE_BITS'(v);
    endfunction

    function automatic logic signed [DW-1:0] dif(input st_word_t a, input st_word_t b);
        return DW'(a) - DW'(b);
    endfunction

    function automatic st_word_t sat_sub(input st_word_t a, input st_word_t b);
        return sat_st(XW'(a) - XW'(b));
    endfunction

    dect_alu #(
        .STATE_BITS (STATE_BITS)
    ) u_alu (
        .aclk (aclk),
        .ctl  (alu_ctl),
        .base (alu_base),
        .diff (alu_diff),
        .res  (alu_res),
        .prod (alu_prod)
    );

    dect_div #(
        .STATE_BITS (STATE_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag     (y_mag[STATE_BITS-1:0]),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // ---------------- input scaling to the state format ----------------
    generate
        if (IN_K >= 0) begin : g_in_up
            assign x_ld = STATE_BITS'($signed(s_tdata[SAMPLE_BITS-1:0])) <<< IN_K;
        end else begin : g_in_dn
            localparam int IR  = -IN_K;
            localparam int XIW = SAMPLE_BITS + 1;
            logic signed [XIW-1:0] x_r;
            assign x_r  = (XIW'($signed(s_tdata[SAMPLE_BITS-1:0])) + XIW'(1 << (IR - 1))) >>> IR;
            assign x_ld = STATE_BITS'(x_r);
        end
    endgenerate

    // ---------------- output scaling and clamp ----------------
    always_comb begin
        o_y = $signed({1'b0, div_quot});
        if (neg_reg) begin
            o_y = -o_y;
        end
    end

    generate
        if (OUT_K >= 0) begin : g_out_up
            localparam int OW = STATE_BITS + 1 + OUT_K;
            localparam logic signed [OW-1:0] O_MAX = OW'((1 << (SAMPLE_BITS - 1)) - 1);
            localparam logic signed [OW-1:0] O_MIN = -O_MAX - OW'(1);
            logic signed [OW-1:0] o_w;
            always_comb begin
                o_w = OW'(o_y) <<< OUT_K;
                if (o_w > O_MAX) begin
                    o_samp = SAMPLE_BITS'(O_MAX);
                end else if (o_w < O_MIN) begin
                    o_samp = SAMPLE_BITS'(O_MIN);
                end else begin
                    o_samp = SAMPLE_BITS'(o_w);
                end
            end
        end else begin : g_out_dn
            localparam int OR = -OUT_K;
            localparam int OW = STATE_BITS + 2;
            localparam logic signed [OW-1:0] O_MAX = OW'((1 << (SAMPLE_BITS - 1)) - 1);
            localparam logic signed [OW-1:0] O_MIN = -O_MAX - OW'(1);
            logic signed [OW-1:0] o_w;
            always_comb begin
                o_w = (OW'(o_y) + OW'(1 << (OR - 1))) >>> OR;
                if (o_w > O_MAX) begin
                    o_samp = SAMPLE_BITS'(O_MAX);
                end else if (o_w < O_MIN) begin
                    o_samp = SAMPLE_BITS'(O_MIN);
                end else begin
                    o_samp = SAMPLE_BITS'(o_w);
                end
            end
        end
    endgenerate

    // ---------------- lo-fi quantizer and body magnitude ----------------
    always_comb begin
        y_mag = y_reg[STATE_BITS-1] ? (STATE_BITS+1)'(-DW'(y_reg))
                                    : (STATE_BITS+1)'(DW'(y_reg));

        if (hold_reg < HOLD_MIN) begin
            hold_c = HOLD_MIN;
        end else if (hold_reg > HOLD_MAX) begin
            hold_c = HOLD_MAX;
        end else begin
            hold_c = hold_reg;
        end
        if (bits_reg < BITS_MIN) begin
            bits_c = BITS_MIN;
        end else if (bits_reg > BITS_MAX) begin
            bits_c = BITS_MAX;
        end else begin
            bits_c = bits_reg;
        end

        // round half away from zero to bits_c fraction bits
        q_k    = (FRAC > int'(bits_c)) ? (6'(FRAC) - 6'(bits_c)) : 6'd0;
        q_half = (q_k != 6'd0) ? ((STATE_BITS+1)'(1) << (q_k - 6'd1)) : '0;
        q_mask = ~(((STATE_BITS+1)'(1) << q_k) - (STATE_BITS+1)'(1));
        q_rnd  = (y_mag + q_half) & q_mask;
        q_sv   = y_reg[STATE_BITS-1] ? -XW'(q_rnd) : XW'(q_rnd);
        q_val  = sat_st(q_sv);
    end

    // body denominator: 2^32 + |y|*k scaled to 32 fraction bits
    assign div_den   = (DEN_W'($unsigned(alu_prod) >> DEN_RSH) << DEN_LSH) + DEN_ONE;
    assign div_start = (st_reg == ST_BODY) && ph_reg;

    // ---------------- operand select for the shared unit ----------------
    always_comb begin
        alu_ctl.sub   = 1'b0;
        alu_ctl.coeff = tone_reg;
        alu_base      = tlp_reg;
        alu_diff      = dif(x_reg, tlp_reg);
        unique case (st_reg)
            ST_HP: begin
                alu_ctl.coeff = hp_reg;
                alu_base      = hpt_reg;
                alu_diff      = dif(y_reg, hpt_reg);
            end
            ST_LP: begin
                alu_ctl.coeff = lp_reg;
                alu_base      = lpo_reg;
                alu_diff      = dif(y_reg, lpo_reg);
            end
            ST_HL: begin
                alu_ctl.coeff = harsh_reg;
                alu_base      = hlo_reg;
                alu_diff      = dif(y_reg, hlo_reg);
            end
            ST_HHL: begin
                alu_ctl.coeff = harsh_reg;
                alu_base      = hhl_reg;
                alu_diff      = dif(a_reg, hhl_reg);
            end
            ST_AMT: begin
                alu_ctl.sub   = 1'b1;
                alu_ctl.coeff = amount_reg;
                alu_base      = y_reg;
                alu_diff      = DW'(a_reg);
            end
            ST_LOFI: begin
                alu_ctl.coeff = LOFI_BLEND;
                alu_base      = y_reg;
                alu_diff      = dif(held_reg, y_reg);
            end
            ST_BODY: begin
                alu_ctl.coeff = slope_reg;
                alu_base      = '0;
                alu_diff      = DW'(y_mag);
            end
            ST_IDLE, ST_TONE, ST_QUANT, ST_DIV, ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // ---------------- configuration registers ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_reg   <= TONE_RST;
            hp_reg     <= HP_RST;
            lp_reg     <= LP_RST;
            harsh_reg  <= HARSH_RST;
            amount_reg <= AMOUNT_RST;
            hold_reg   <= HOLD_RST;
            bits_reg   <= BITS_RST;
            slope_reg  <= SLOPE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TONE:   tone_reg   <= cfg_data;
                REG_HP:     hp_reg     <= cfg_data;
                REG_LP:     lp_reg     <= cfg_data;
                REG_HARSH:  harsh_reg  <= cfg_data;
                REG_AMOUNT: amount_reg <= cfg_data;
                REG_HOLD:   hold_reg   <= cfg_data[HOLD_W-1:0];
                REG_BITS:   bits_reg   <= cfg_data[HOLD_W-1:0];
                REG_SLOPE:  slope_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(o_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            ph_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                ch_tlp_reg[i]  <= '0;
                ch_hpt_reg[i]  <= '0;
                ch_lpo_reg[i]  <= '0;
                ch_hlo_reg[i]  <= '0;
                ch_hhl_reg[i]  <= '0;
                ch_held_reg[i] <= '0;
                ch_cnt_reg[i]  <= '0;
            end
        end else begin
            // the output step reloads the result register itself
            if (m_tvalid_reg && m_tready && (st_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        chan_reg <= s_tuser;
                        x_reg    <= x_ld;
                        tlp_reg  <= ch_tlp_reg[s_tuser];
                        hpt_reg  <= ch_hpt_reg[s_tuser];
                        lpo_reg  <= ch_lpo_reg[s_tuser];
                        hlo_reg  <= ch_hlo_reg[s_tuser];
                        hhl_reg  <= ch_hhl_reg[s_tuser];
                        held_reg <= ch_held_reg[s_tuser];
                        cnt_reg  <= ch_cnt_reg[s_tuser];
                        st_reg   <= ST_TONE;
                        ph_reg   <= 1'b0;
                    end
                end
                ST_TONE: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        tlp_reg <= alu_res;
                        y_reg   <= alu_res;
                        st_reg  <= ST_HP;
                    end
                end
                ST_HP: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        hpt_reg <= alu_res;
                        y_reg   <= sat_sub(y_reg, alu_res);
                        st_reg  <= ST_LP;
                    end
                end
                ST_LP: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        lpo_reg <= alu_res;
                        y_reg   <= alu_res;
                        st_reg  <= ST_HL;
                    end
                end
                ST_HL: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        hlo_reg <= alu_res;
                        a_reg   <= sat_sub(y_reg, alu_res);   // harsh highpass
                        st_reg  <= ST_HHL;
                    end
                end
                ST_HHL: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        hhl_reg <= alu_res;
                        a_reg   <= sat_sub(a_reg, alu_res);   // harsh band
                        st_reg  <= ST_AMT;
                    end
                end
                ST_AMT: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        y_reg  <= alu_res;
                        st_reg <= (hold_reg != '0) ? ST_QUANT : ST_BODY;
                    end
                end
                ST_QUANT: begin
                    // y already holds the post-harsh value
                    if (cnt_reg == '0) begin
                        cnt_reg  <= hold_c - 1'b1;
                        held_reg <= q_val;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                    st_reg <= ST_LOFI;
                end
                ST_LOFI: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        y_reg  <= alu_res;
                        st_reg <= ST_BODY;
                    end
                end
                ST_BODY: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        neg_reg <= y_reg[STATE_BITS-1];
                        st_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        st_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        o_data_reg           <= o_samp;
                        m_tvalid_reg         <= 1'b1;
                        ch_tlp_reg[chan_reg]  <= tlp_reg;
                        ch_hpt_reg[chan_reg]  <= hpt_reg;
                        ch_lpo_reg[chan_reg]  <= lpo_reg;
                        ch_hlo_reg[chan_reg]  <= hlo_reg;
                        ch_hhl_reg[chan_reg]  <= hhl_reg;
                        ch_held_reg[chan_reg] <= held_reg;
                        ch_cnt_reg[chan_reg]  <= cnt_reg;
                        st_reg               <= ST_IDLE;
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // no item is taken while the divider still works on the last one
    a_accept_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> !div_stat.busy)
        else $error("item accepted while divider busy");

    // a divide finishes only after a run of busy cycles
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> $past(div_stat.busy))
        else $error("divider done without a busy run");

    // y/(1+|y|k) never exceeds |y|
    a_quot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> ((STATE_BITS+1)'(div_quot) <= y_mag))
        else $error("body quotient above magnitude");

    // stored countdowns stay below the longest hold
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ch_cnt_reg[0] < HOLD_MAX) && (ch_cnt_reg[1] < HOLD_MAX))
        else $error("lo-fi countdown out of range");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking bench for the echo tone chain: streamed items, bit-true prediction, compare.
module tb_top;
    import dect_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int STATE_W  = 24;
    localparam int FRAC_W   = STATE_W - 2;     // internal words carry two integer bits
    localparam int COEF_W   = 16;

    localparam longint STATE_MAX  = (64'sd1 <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN  = -(64'sd1 <<< (STATE_W - 1));
    localparam longint OUT_MAX    = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN    = -(64'sd1 <<< (SAMPLE_W - 1));
    localparam longint BLEND_Q16  = LOFI_BLEND;
    localparam int     HOLD_FLOOR = int'(HOLD_MIN);
    localparam int     HOLD_CEIL  = int'(HOLD_MAX);
    localparam int     BITS_FLOOR = int'(BITS_MIN);
    localparam int     BITS_CEIL  = int'(BITS_MAX);

    localparam int NUM_SEGMENTS   = 10;    // one register setting per segment
    localparam int SEG_ITEMS      = 185;
    localparam int TAIL_CYCLES    = 60;    // a bit over one item's worth of work
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample_in;
    } echo_item_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata   = '0;
    logic                s_tuser   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [SAMPLE_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    cfg_idx_t            cfg_index = REG_TONE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    delay_echo_tone_chain DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    echo_item_t                 echo_in_q[$];     // items waiting to be sent
    logic signed [SAMPLE_W-1:0] echo_out_q[$];    // predicted sample_out, oldest first
    int queued_count;
    int accepted_count;
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int stuck_cycles;
    echo_item_t item_taken;
    echo_item_t item_next;

    // predictor copy of the registers
    int tone_c, hp_c, lp_c, harsh_c, amount_c, hold_len, lofi_bits, slope_k;
    // predictor copy of the per-channel filter state
    longint tone_lp[2], hp_track[2], lp_out[2], harsh_lo[2], harsh_hl[2], lofi_held[2];
    int     lofi_cd[2];

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint sat_state(longint v);
        return (v > STATE_MAX) ? STATE_MAX : ((v < STATE_MIN) ? STATE_MIN : v);
    endfunction

    // s += round(c * (x - s) / 2^16), round = add half then floor
    function automatic longint one_pole(longint s, longint x, int c);
        longint p;
        p = longint'(c) * (x - s) + (64'sd1 <<< (COEF_W - 1));
        return sat_state(s + (p >>> COEF_W));
    endfunction

    // round half away from zero to 'bits' fraction bits
    function automatic longint quantize(longint v, int bits);
        int     k;
        longint m;
        k = FRAC_W - bits;
        if (k <= 0)
            return v;
        m = (v < 0) ? -v : v;
        m = ((m + (64'sd1 <<< (k - 1))) >>> k) <<< k;
        return sat_state((v < 0) ? -m : m);
    endfunction

    // y / (1 + |y|*k), quotient truncated toward zero
    function automatic longint body_compress(longint v, int k);
        longint mag, den, q;
        mag = (v < 0) ? -v : v;
        den = (64'sd1 <<< 32) + ((mag * longint'(k)) >>> (FRAC_W - 16));
        q   = (mag <<< 32) / den;
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] condition_echo(echo_item_t it);
        int     ch, hold, bits;
        longint x, y, ahp, band;
        ch = it.channel;
        x  = $signed(it.sample_in);
        x  = sat_state(x <<< (FRAC_W - (SAMPLE_W - 1)));

        tone_lp[ch]  = one_pole(tone_lp[ch], x, tone_c);
        y            = tone_lp[ch];
        hp_track[ch] = one_pole(hp_track[ch], y, hp_c);
        y            = sat_state(y - hp_track[ch]);
        lp_out[ch]   = one_pole(lp_out[ch], y, lp_c);
        y            = lp_out[ch];

        // harsh band: highpass of y, then highpass of that, subtracted in part
        harsh_lo[ch] = one_pole(harsh_lo[ch], y, harsh_c);
        ahp          = sat_state(y - harsh_lo[ch]);
        harsh_hl[ch] = one_pole(harsh_hl[ch], ahp, harsh_c);
        band         = sat_state(ahp - harsh_hl[ch]);
        y = sat_state(y - ((longint'(amount_c) * band + (64'sd1 <<< (COEF_W - 1))) >>> COEF_W));

        // lo-fi off leaves countdown and held value untouched
        if (hold_len != 0) begin
            hold = (hold_len < HOLD_FLOOR) ? HOLD_FLOOR :
                   ((hold_len > HOLD_CEIL) ? HOLD_CEIL : hold_len);
            bits = (lofi_bits < BITS_FLOOR) ? BITS_FLOOR :
                   ((lofi_bits > BITS_CEIL) ? BITS_CEIL : lofi_bits);
            if (lofi_cd[ch] == 0) begin
                lofi_cd[ch]   = hold;
                lofi_held[ch] = quantize(y, bits);
            end
            lofi_cd[ch] = (lofi_cd[ch] - 1) & 'hF;
            y = sat_state(y + ((BLEND_Q16 * (lofi_held[ch] - y)
                                + (64'sd1 <<< (COEF_W - 1))) >>> COEF_W));
        end

        y = body_compress(y, slope_k);
        y = (y + (64'sd1 <<< (FRAC_W - SAMPLE_W))) >>> (FRAC_W - (SAMPLE_W - 1));
        y = (y > OUT_MAX) ? OUT_MAX : ((y < OUT_MIN) ? OUT_MIN : y);
        return y[SAMPLE_W-1:0];
    endfunction

    function automatic void reset_model();
        tone_c    = TONE_RST;
        hp_c      = HP_RST;
        lp_c      = LP_RST;
        harsh_c   = HARSH_RST;
        amount_c  = AMOUNT_RST;
        hold_len  = HOLD_RST;
        lofi_bits = BITS_RST;
        slope_k   = SLOPE_RST;
        for (int c = 0; c < 2; c++) begin
            tone_lp[c]   = 0;
            hp_track[c]  = 0;
            lp_out[c]    = 0;
            harsh_lo[c]  = 0;
            harsh_hl[c]  = 0;
            lofi_held[c] = 0;
            lofi_cd[c]   = 0;
        end
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Register writes (only while nothing is in flight)
    // ------------------------------------------------------------------
    task automatic write_reg(cfg_idx_t idx, int val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TONE:   tone_c    = val & 'hFFFF;
            REG_HP:     hp_c      = val & 'hFFFF;
            REG_LP:     lp_c      = val & 'hFFFF;
            REG_HARSH:  harsh_c   = val & 'hFFFF;
            REG_AMOUNT: amount_c  = val & 'hFFFF;
            REG_HOLD:   hold_len  = val & 'hF;
            REG_BITS:   lofi_bits = val & 'hF;
            REG_SLOPE:  slope_k   = val & 'hFFFF;
        endcase
    endtask

    task automatic write_all(int t, int hp, int lp, int hr, int am, int ho, int bi, int sl);
        write_reg(REG_TONE, t);
        write_reg(REG_HP, hp);
        write_reg(REG_LP, lp);
        write_reg(REG_HARSH, hr);
        write_reg(REG_AMOUNT, am);
        write_reg(REG_HOLD, ho);
        write_reg(REG_BITS, bi);
        write_reg(REG_SLOPE, sl);
    endtask

    task automatic apply_setting(int seg);
        case (seg)
            // everything at full scale, longest hold
            1: write_all(65535, 65535, 65535, 65535, 65535, 12, 14, 65535);
            // all coefficients and the hold at zero: filters frozen, lo-fi off
            2: write_all(0, 0, 0, 0, 0, 0, 10, 0);
            // hold of one acts as two, bit count below range clamps up
            3: write_all(65535, 0, 65535, 0, 65535, 1, 0, 0);
            // hold above twelve and bit count above fourteen both clamp
            4: write_all(45000, 1030, 35000, 26000, 12000, 15, 15, 7864);
            // lo-fi off: countdown and held value must survive to segment 7
            6: write_all(60000, 200, 50000, 40000, 30000, 0, 12, 30000);
            7: write_all(60000, 200, 50000, 40000, 30000, 5, 11, 30000);
            9: write_all(65535, 65535, 65535, 20000, 65535, 2, 10, 65535);
            default: write_all($urandom_range(65535), $urandom_range(65535),
                               $urandom_range(65535), $urandom_range(65535),
                               $urandom_range(65535), $urandom_range(15),
                               $urandom_range(15), $urandom_range(65535));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(logic ch, int v);
        echo_item_t it;
        it.channel   = ch;
        it.sample_in = v[SAMPLE_W-1:0];
        echo_in_q.push_back(it);
        queued_count++;
    endtask

    task automatic queue_random(int n);
        int   left, run, amp;
        logic ch;
        left = n;
        while (left > 0) begin
            case ($urandom_range(9))
                0: begin
                    // square burst on one channel: pushes the band and lo-fi paths hard
                    ch  = 1'($urandom_range(1));
                    run = $urandom_range(24, 8);
                    amp = $urandom_range(1) ? 32767 : $urandom_range(32767, 8192);
                    for (int i = 0; i < run && left > 0; i++) begin
                        queue_item(ch, ((i / 2) % 2) ? -amp - 1 : amp);
                        left--;
                    end
                end
                1: begin
                    queue_item(1'($urandom_range(1)), $urandom_range(1) ? 32767 : -32768);
                    left--;
                end
                2, 3: begin
                    queue_item(1'($urandom_range(1)), int'($urandom_range(511)) - 256);
                    left--;
                end
                default: begin
                    queue_item(1'($urandom_range(1)), int'($urandom_range(65535)) - 32768);
                    left--;
                end
            endcase
        end
    endtask

    // the sequence holds off until every item is in and every result is out
    task automatic wait_drained();
        while (accepted_count != queued_count || echo_out_q.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Driver: pops pending items, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                item_taken.channel   = s_tuser;
                item_taken.sample_in = s_tdata;
                echo_out_q.push_back(condition_echo(item_taken));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (echo_in_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_next = echo_in_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= item_next.channel;
                    s_tdata  <= item_next.sample_in;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (echo_out_q.size() == 0)
                    report_mismatch($sformatf("unexpected sample_out %0d",
                                              $signed(m_tdata)));
                else if (m_tdata !== echo_out_q[0])
                    report_mismatch($sformatf("sample_out got %0d want %0d",
                                              $signed(m_tdata), echo_out_q[0]));
                if (echo_out_q.size() != 0)
                    void'(echo_out_q.pop_front());
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any handshake clears it
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        queued_count   = 0;
        accepted_count = 0;
        mismatches     = 0;
        send_idle_pct  = 6;
        recv_idle_pct  = 54;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed items at reset settings: field extremes on both channels
        queue_item(1'b0, 32767);
        queue_item(1'b0, 32767);
        queue_item(1'b0, -32768);
        queue_item(1'b0, -32768);
        queue_item(1'b0, 0);
        queue_item(1'b0, 1);
        queue_item(1'b0, -1);
        queue_item(1'b0, 16384);
        queue_item(1'b0, -16384);
        queue_item(1'b0, 32767);
        queue_item(1'b1, -32768);
        queue_item(1'b1, 32767);
        queue_item(1'b1, -32768);
        queue_item(1'b1, 32767);
        queue_item(1'b1, 0);
        queue_item(1'b1, -1);
        queue_item(1'b1, 1);
        queue_item(1'b1, 12345);
        queue_item(1'b1, -12345);
        queue_item(1'b1, 0);
        queue_random(SEG_ITEMS - 20);
        wait_drained();

        for (int seg = 1; seg < NUM_SEGMENTS; seg++) begin
            // idle mix: slow receiver, then slow sender, then full rate
            if (seg < 4) begin
                send_idle_pct = 6;
                recv_idle_pct = 54;
            end else if (seg < 7) begin
                send_idle_pct = 54;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(seg);
            queue_random(SEG_ITEMS);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (echo_out_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", echo_out_q.size()));
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/dect_pkg.sv
rtl/dect_alu.sv
rtl/dect_div.sv
rtl/delay_echo_tone_chain.sv
tb/sv/tb_top.sv
